[hw/rtl/ffa_pkg.sv]
`timescale 1ns / 1ps
package ffa_pkg;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_BAD     = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [13:0] req_size;
      logic [13:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] payload_offset;
   } rsp_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_RD,
      FSM_CHK,
      FSM_RDA,
      FSM_MODA,
      FSM_RDB,
      FSM_MODB,
      FSM_MODC,
      FSM_DONE
   } fsm_type;

endpackage

[hw/rtl/ffa_ram.sv]
`timescale 1ns / 1ps
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/first_fit_allocator.sv]
`timescale 1ns / 1ps
// First-fit arena allocator with coalescing.
// Request words (req_valid/req_ready, req_data) carry a mode bit, a size for
// an allocate and a payload offset for a free. Every request returns exactly
// one response word (rsp_valid/rsp_ready, rsp_data) with a status and, for a
// successful allocate, the payload offset (segment start plus header).
// The segment table lives in one synchronous RAM with one entry per slot
// (start, size, free, next, prev); in-use flags are flip-flops so that the
// first unused slot is found by a priority search. Requests are handled one
// at a time. After the accepting edge state RD issues the first read, then
// the list walk (allocate) or the slot search (free) checks one entry per
// cycle, at most MAX_SEGMENTS entries. The neighbour updates then pass
// through RDA, MODA, RDB, MODB and MODC as the case needs, and DONE raises
// the response word. Reset empties the table to one free segment covering
// the whole arena; the other RAM entries are written before they are ever
// read, so no clearing pass is needed. When the receiver stalls the finished
// response word is held in the output register and the next request waits
// until it has left.
module first_fit_allocator #(
   parameter int ARENA_BYTES  = 16384,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffa_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_SEGMENTS);   // slot index bits
   localparam int OW = $clog2(ARENA_BYTES) + 1; // offsets at full precision
   localparam logic [OW-1:0] HDR = OW'(HEADER_BYTES);

   // One table entry. A link is valid when its flag is set.
   typedef struct packed {
      logic [OW-1:0] start;
      logic [OW-1:0] size;
      logic          free;
      logic          nxt_v;
      logic [AW-1:0] nxt;
      logic          prv_v;
      logic [AW-1:0] prv;
   } ent_type;
   localparam int EW = $bits(ent_type);

   ffa_pkg::fsm_type state_ff, state_in;
   logic [MAX_SEGMENTS-1:0] used_ff, used_in;
   logic [AW-1:0] cur_ff, cur_in;       // walk pointer / keeper slot
   logic [AW:0]   steps_ff, steps_in;
   ffa_pkg::req_type req_ff, req_in;
   ent_type ent_ff, ent_in;             // the entry being acted on
   logic [AW-1:0] ns_ff, ns_in;         // new or neighbour slot
   logic [AW-1:0] keep_ff, keep_in;     // old successor of a split segment
   logic          init_ff, init_in;     // slot zero still at reset value
   ffa_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   ent_type       wr_data, rd_raw, rd_ent;
   logic [AW-1:0] rd_addr_ff;

   ffa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Slot zero reads as the whole free arena until it is first written.
   always_comb begin
      rd_ent = rd_raw;
      if (init_ff && rd_addr_ff == '0) begin
         rd_ent = '0;
         rd_ent.free = 1'b1;
         rd_ent.size = OW'(ARENA_BYTES) - HDR;
      end
   end

   logic          has_unused;
   logic [AW-1:0] first_unused;
   always_comb begin
      has_unused = 1'b0;
      first_unused = '0;
      for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            has_unused = 1'b1;
            first_unused = AW'(i);
         end
      end
   end

   logic [OW-1:0] req_w, off_w;
   assign req_w = OW'(req_ff.req_size);
   assign off_w = OW'(req_ff.free_offset);

   // Decisions taken on the entry that has just been read.
   logic fit_w, split_w, hit_w, walk_more, scan_more;
   assign fit_w     = rd_ent.free && rd_ent.size >= req_w;
   assign split_w   = req_w + HDR <= rd_ent.size;
   assign hit_w     = used_ff[cur_ff] && !rd_ent.free && rd_ent.start + HDR == off_w;
   assign scan_more = (steps_ff + 1'b1) < (AW+1)'(MAX_SEGMENTS);
   assign walk_more = rd_ent.nxt_v && scan_more;

   assign req_ready = (state_ff == ffa_pkg::FSM_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffa_pkg::FSM_IDLE: if (req_valid && req_ready) state_in = ffa_pkg::FSM_RD;
         ffa_pkg::FSM_RD:   state_in = ffa_pkg::FSM_CHK;
         ffa_pkg::FSM_CHK: begin
            if (req_ff.mode == ffa_pkg::MODE_ALLOC) begin
               if (fit_w) begin
                  if (split_w && !has_unused) begin
                     state_in = ffa_pkg::FSM_DONE;
                  end else if (split_w && rd_ent.nxt_v) begin
                     state_in = ffa_pkg::FSM_RDA;
                  end else begin
                     state_in = ffa_pkg::FSM_MODC;
                  end
               end else if (walk_more) begin
                  state_in = ffa_pkg::FSM_CHK;
               end else begin
                  state_in = ffa_pkg::FSM_DONE;
               end
            end else begin
               if (hit_w) begin
                  // Look at the predecessor first.
                  state_in = rd_ent.prv_v ? ffa_pkg::FSM_RDA : ffa_pkg::FSM_RDB;
               end else if (scan_more) begin
                  state_in = ffa_pkg::FSM_CHK;
               end else begin
                  state_in = ffa_pkg::FSM_DONE;
               end
            end
         end
         ffa_pkg::FSM_RDA:  state_in = ffa_pkg::FSM_MODA;
         ffa_pkg::FSM_MODA: state_in = (req_ff.mode == ffa_pkg::MODE_ALLOC) ?
                                       ffa_pkg::FSM_MODC : ffa_pkg::FSM_RDB;
         ffa_pkg::FSM_RDB:  state_in = ent_ff.nxt_v ? ffa_pkg::FSM_MODB : ffa_pkg::FSM_MODC;
         ffa_pkg::FSM_MODB: state_in = ffa_pkg::FSM_MODC;
         ffa_pkg::FSM_MODC: state_in = ffa_pkg::FSM_DONE;
         ffa_pkg::FSM_DONE: state_in = ffa_pkg::FSM_IDLE;
         default:           state_in = ffa_pkg::FSM_IDLE;
      endcase
   end

   // Datapath of the walk and the neighbour updates.
   always_comb begin
      used_in = used_ff;
      cur_in = cur_ff;
      steps_in = steps_ff;
      req_in = req_ff;
      ent_in = ent_ff;
      ns_in = ns_ff;
      keep_in = keep_ff;
      init_in = init_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = ent_ff;
      rd_addr = cur_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ffa_pkg::FSM_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               steps_in = '0;
               cur_in = '0;
               rsp_in = '0;
            end
         end
         ffa_pkg::FSM_RD: begin
            rd_addr = cur_ff;
         end
         ffa_pkg::FSM_CHK: begin
            ent_in = rd_ent;
            if (req_ff.mode == ffa_pkg::MODE_ALLOC) begin
               if (fit_w) begin
                  if (split_w) begin
                     if (!has_unused) begin
                        rsp_in.status = ffa_pkg::ST_FULL;
                     end else begin
                        // Split: write the new free remainder first.
                        ns_in = first_unused;
                        used_in[first_unused] = 1'b1;
                        wr_en = 1'b1;
                        wr_addr = first_unused;
                        wr_data.start = rd_ent.start + HDR + req_w;
                        wr_data.size  = rd_ent.size - HDR - req_w;
                        wr_data.free  = 1'b1;
                        wr_data.nxt_v = rd_ent.nxt_v;
                        wr_data.nxt   = rd_ent.nxt;
                        wr_data.prv_v = 1'b1;
                        wr_data.prv   = cur_ff;
                        ent_in.size  = req_w;
                        ent_in.free  = 1'b0;
                        ent_in.nxt_v = 1'b1;
                        ent_in.nxt   = first_unused;
                        keep_in = rd_ent.nxt;
                        rsp_in.payload_offset = 14'(rd_ent.start + HDR);
                     end
                  end else begin
                     ent_in.free = 1'b0;
                     rsp_in.payload_offset = 14'(rd_ent.start + HDR);
                  end
               end else if (walk_more) begin
                  cur_in = rd_ent.nxt;
                  steps_in = steps_ff + 1'b1;
                  rd_addr = rd_ent.nxt;
               end else begin
                  rsp_in.status = ffa_pkg::ST_NO_FIT;
               end
            end else if (!hit_w) begin
               if (scan_more) begin
                  cur_in = cur_ff + 1'b1;
                  steps_in = steps_ff + 1'b1;
                  rd_addr = cur_ff + 1'b1;
               end else begin
                  rsp_in.status = ffa_pkg::ST_BAD;
               end
            end
         end
         ffa_pkg::FSM_RDA: begin
            // Allocate: read old successor; free: read predecessor.
            rd_addr = (req_ff.mode == ffa_pkg::MODE_ALLOC) ? keep_ff : ent_ff.prv;
         end
         ffa_pkg::FSM_MODA: begin
            if (req_ff.mode == ffa_pkg::MODE_ALLOC) begin
               wr_en = 1'b1;
               wr_addr = keep_ff;
               wr_data = rd_ent;
               wr_data.prv_v = 1'b1;
               wr_data.prv = ns_ff;
               if (keep_ff == '0) init_in = 1'b0;
            end else if (rd_ent.free) begin
               // The free predecessor becomes the keeper; release this slot.
               ent_in = rd_ent;
               ent_in.size = rd_ent.size + HDR + ent_ff.size;
               ent_in.nxt_v = ent_ff.nxt_v;
               ent_in.nxt = ent_ff.nxt;
               used_in[cur_ff] = 1'b0;
               cur_in = ent_ff.prv;
            end
         end
         ffa_pkg::FSM_RDB: begin
            // The keeper is free; look at its successor.
            ent_in.free = 1'b1;
            rd_addr = ent_ff.nxt;
            ns_in = ent_ff.nxt;
         end
         ffa_pkg::FSM_MODB: begin
            if (rd_ent.free) begin
               // Absorb the successor into the keeper.
               ent_in.size = ent_ff.size + HDR + rd_ent.size;
               ent_in.nxt_v = rd_ent.nxt_v;
               ent_in.nxt = rd_ent.nxt;
               used_in[ns_ff] = 1'b0;
               ns_in = rd_ent.nxt;
            end
         end
         ffa_pkg::FSM_MODC: begin
            // Write the keeper and fetch the segment that now follows it.
            wr_en = 1'b1;
            wr_addr = cur_ff;
            wr_data = ent_ff;
            if (cur_ff == '0) init_in = 1'b0;
            rd_addr = ns_ff;
         end
         ffa_pkg::FSM_DONE: begin
            // After a successful free the following segment points back at
            // the keeper.
            if (req_ff.mode == ffa_pkg::MODE_FREE && rsp_ff.status == ffa_pkg::ST_OK
                && ent_ff.nxt_v) begin
               wr_en = 1'b1;
               wr_addr = ns_ff;
               wr_data = rd_ent;
               wr_data.prv_v = 1'b1;
               wr_data.prv = cur_ff;
               if (ns_ff == '0) init_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::FSM_IDLE;
         used_ff <= MAX_SEGMENTS'(1);
         init_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         init_ff <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      steps_ff <= steps_in;
      req_ff <= req_in;
      ent_ff <= ent_in;
      ns_ff <= ns_in;
      keep_ff <= keep_in;
      rsp_ff <= rsp_in;
      rd_addr_ff <= rd_addr;
   end

`ifndef NO_ASSERTIONS
   a_slot0_used: assert property (@(posedge clock) disable iff (reset) used_ff[0])
      else $error("slot zero released");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(req_valid && req_ready))
      else $error("request taken while response pending");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffa_pkg::FSM_DONE |=> rsp_valid_ff)
      else $error("finished item without response");
`endif

endmodule

[tb/sv/first_fit_checker.sv]
`timescale 1ns / 1ps
// Watches both channels, keeps its own copy of the segment table and
// compares every response word with the oldest predicted one.
module first_fit_checker #(
   parameter int ARENA_BYTES  = 16384,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ffa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ffa_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   localparam int NO_LINK = -1;

   int unsigned sg_start [MAX_SEGMENTS];
   int unsigned sg_size  [MAX_SEGMENTS];
   bit          sg_free  [MAX_SEGMENTS];
   bit          sg_used  [MAX_SEGMENTS];
   int          sg_next  [MAX_SEGMENTS];
   int          sg_prev  [MAX_SEGMENTS];
   ffa_pkg::rsp_type expected_words[$];

   function automatic bit is_link(int l);
      return l != NO_LINK && l >= 0 && l < MAX_SEGMENTS;
   endfunction

   function automatic void drop_slot(int s);
      sg_used[s] = 0; sg_free[s] = 0; sg_size[s] = 0; sg_start[s] = 0;
      sg_next[s] = NO_LINK; sg_prev[s] = NO_LINK;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < MAX_SEGMENTS; i++) drop_slot(i);
      sg_used[0] = 1;
      sg_free[0] = 1;
      sg_size[0] = ARENA_BYTES - HEADER_BYTES;
   endfunction

   function automatic ffa_pkg::rsp_type grant_segment(int unsigned want);
      ffa_pkg::rsp_type r;
      int cur, ns;
      r = '0;
      cur = 0;
      for (int steps = 0; steps < MAX_SEGMENTS && is_link(cur); steps++) begin
         if (sg_used[cur] && sg_free[cur] && sg_size[cur] >= want) begin
            if (want + HEADER_BYTES <= sg_size[cur]) begin
               ns = NO_LINK;
               for (int i = MAX_SEGMENTS - 1; i >= 0; i--)
                  if (!sg_used[i]) ns = i;
               if (ns == NO_LINK) begin
                  r.status = ffa_pkg::ST_FULL;
                  return r;
               end
               sg_used[ns] = 1;
               sg_free[ns] = 1;
               sg_start[ns] = sg_start[cur] + HEADER_BYTES + want;
               sg_size[ns] = sg_size[cur] - HEADER_BYTES - want;
               sg_next[ns] = sg_next[cur];
               sg_prev[ns] = cur;
               if (is_link(sg_next[cur])) sg_prev[sg_next[cur]] = ns;
               sg_next[cur] = ns;
               sg_size[cur] = want;
            end
            sg_free[cur] = 0;
            r.status = ffa_pkg::ST_OK;
            r.payload_offset = 14'(sg_start[cur] + HEADER_BYTES);
            return r;
         end
         cur = sg_next[cur];
      end
      r.status = ffa_pkg::ST_NO_FIT;
      return r;
   endfunction

   function automatic ffa_pkg::rsp_type release_segment(int unsigned off);
      ffa_pkg::rsp_type r;
      int p, keep, pv, nx;
      r = '0;
      p = NO_LINK;
      for (int i = MAX_SEGMENTS - 1; i >= 0; i--)
         if (sg_used[i] && !sg_free[i] && sg_start[i] + HEADER_BYTES == off) p = i;
      if (p == NO_LINK) begin
         r.status = ffa_pkg::ST_BAD;
         return r;
      end
      keep = p;
      pv = sg_prev[p];
      if (is_link(pv) && sg_free[pv]) begin
         sg_size[pv] += HEADER_BYTES + sg_size[p];
         sg_next[pv] = sg_next[p];
         if (is_link(sg_next[p])) sg_prev[sg_next[p]] = pv;
         drop_slot(p);
         keep = pv;
      end else begin
         sg_free[p] = 1;
      end
      nx = sg_next[keep];
      if (is_link(nx) && sg_free[nx]) begin
         sg_size[keep] += HEADER_BYTES + sg_size[nx];
         sg_next[keep] = sg_next[nx];
         if (is_link(sg_next[nx])) sg_prev[sg_next[nx]] = keep;
         drop_slot(nx);
      end
      r.status = ffa_pkg::ST_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      ffa_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         clear_table();
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.mode == ffa_pkg::MODE_ALLOC)
               expected_words.push_back(grant_segment(req_data.req_size));
            else
               expected_words.push_back(release_segment(req_data.free_offset));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with none expected: %h", rsp_data);
               errs++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (rsp_data.payload_offset !== want.payload_offset) begin
                  $error("payload_offset: expected %0d, actual %0d",
                         want.payload_offset, rsp_data.payload_offset);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= expected_words.size();
   end
endmodule

[tb/sv/tb_first_fit_allocator.sv]
`timescale 1ns / 1ps
// Top of the allocator testbench. It only makes stimulus and gives the
// verdict; all prediction and comparison sit in the checker beside the block.
module tb_first_fit_allocator;

   localparam int ARENA     = 16384;
   localparam int HDR       = 16;
   localparam int RANDOM_N  = 1300;
   localparam int CYCLE_CAP = 1200000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   ffa_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   ffa_pkg::rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;
   bit      calm = 0;          // set for the last part of the run: no idling

   // Offsets of payloads we believe are live, so that most frees hit.
   int      live_offsets[$];

   always #4 clock = ~clock;

   first_fit_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   first_fit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // A run that hangs is cut off here and counted as failed.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The receiver stalls in bursts, with calm spells between.
   always @(posedge clock) begin
      int burst;
      if (reset || calm) begin
         rsp_ready <= !reset;
      end else if (burst > 0) begin
         burst--;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
         burst = $urandom_range(0, 5);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   // Sends one request word and holds it until it is accepted. The word
   // stays up across back-to-back sends; valid only drops when a gap follows.
   task automatic send_word(logic mode, logic [13:0] size, logic [13:0] off);
      int gap;
      req_valid <= 1;
      req_data  <= '{mode: mode, req_size: size, free_offset: off};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Now and then leave an idle gap before the next word.
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic alloc_word(logic [13:0] size);
      send_word(ffa_pkg::MODE_ALLOC, size, 14'($urandom));
   endtask

   task automatic free_word(logic [13:0] off);
      send_word(ffa_pkg::MODE_FREE, 14'($urandom), off);
   endtask

   // Learn granted offsets from successful allocate responses.
   logic last_mode_q[$];
   always @(posedge clock) begin
      logic m;
      if (!reset) begin
         if (req_valid && req_ready) last_mode_q.push_back(req_data.mode);
         if (rsp_valid && rsp_ready && last_mode_q.size() > 0) begin
            m = last_mode_q.pop_front();
            if (m == ffa_pkg::MODE_ALLOC && rsp_data.status == ffa_pkg::ST_OK)
               live_offsets.push_back(rsp_data.payload_offset);
         end
      end
   end

   function automatic logic [13:0] pick_live();
      int k;
      logic [13:0] o;
      if (live_offsets.size() == 0) return 14'($urandom);
      k = $urandom_range(0, live_offsets.size() - 1);
      o = live_offsets[k];
      live_offsets.delete(k);
      return o;
   endfunction

   function automatic logic [13:0] random_size();
      case ($urandom_range(0, 9))
         0:       return 14'($urandom);
         1:       return 14'($urandom_range(0, 3));
         2, 3:    return 14'($urandom_range(0, 1023));
         default: return 14'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int choice;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extremes, exact fit, zero-payload remainder, no fit,
      // bad and double free, coalescing with the successor.
      alloc_word(14'h3fff);                    // no fitting segment
      alloc_word(14'(ARENA - HDR));            // whole arena, no split
      alloc_word(14'd0);                       // no fit, arena taken
      free_word(14'(HDR));                     // frees whole arena
      free_word(14'(HDR));                     // double free
      free_word(14'd0);                        // unknown address
      free_word(14'h3fff);                     // unknown address
      alloc_word(14'(ARENA - 2 * HDR));        // split, zero-payload remainder
      free_word(14'(HDR));                     // merges with empty successor
      alloc_word(14'd0);                       // zero-size grant
      alloc_word(14'd100);
      alloc_word(14'd200);
      free_word(14'(2 * HDR + 100));           // unknown address, not a payload offset
      free_word(14'(HDR));                     // frees zero-size segment, successor in use
      free_word(14'(3 * HDR + 100));           // merges with free successor only
      // Exhaust the segment table with tiny grants.
      for (int i = 0; i < 66; i++) alloc_word(14'd0);
      alloc_word(14'd1);
      repeat (5) free_word(pick_live());

      // Random part: mostly sensible alloc/free traffic with some noise.
      for (int n = 0; n < RANDOM_N; n++) begin
         if (n > RANDOM_N - 150) calm = 1;
         choice = $urandom_range(0, 99);
         if (choice < 50)
            alloc_word(random_size());
         else if (choice < 90)
            free_word(pick_live());
         else
            free_word(14'($urandom));
      end
      req_valid <= 0;

      repeat (2) @(posedge clock);
      while (pending > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
